>>> sv/lr_pkg.sv
package lr_pkg;

  // coordinate width of every endpoint and pixel
  localparam int COORD_BITS = 6;
  localparam int GLYPH_BITS = 8;

  // error term of the walk: holds values in (-2*span, 2*span]
  localparam int ERR_W = COORD_BITS + 3;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_FIELD_W  = 4 * COORD_BITS + GLYPH_BITS;
  localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 2 * COORD_BITS + GLYPH_BITS;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // command queue between classifier and stepper
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [COORD_BITS-1:0] coord_t;

  // one classified line, ready to be walked
  typedef struct packed {
    coord_t                 start_x;
    coord_t                 start_y;
    coord_t                 stop;       // last coordinate on the major axis
    logic                   major_y;    // major axis is y
    logic                   major_neg;  // major axis walks downward
    logic                   minor_neg;  // minor axis walks downward
    logic [COORD_BITS:0]    a2;         // twice the minor span
    logic [COORD_BITS:0]    b2;         // twice the major span
    logic signed [ERR_W-1:0] err0;      // initial error, 2*minor - major
    logic [GLYPH_BITS-1:0]  glyph;
  } line_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } step_state_t;

endpackage

>>> sv/lr_classify.sv
module lr_classify (
  input  logic [lr_pkg::IN_DATA_W-1:0] cmd_data,
  output lr_pkg::line_cmd_t            cmd
);
  import lr_pkg::*;

  coord_t x0, y0, x1, y1;
  coord_t lx, ly, rx, ry;
  coord_t dx, ady;
  logic   swap, y_down, shallow;
  coord_t minor_span, major_span;

  // unpack the transaction
  assign x0 = cmd_data[0*COORD_BITS +: COORD_BITS];
  assign y0 = cmd_data[1*COORD_BITS +: COORD_BITS];
  assign x1 = cmd_data[2*COORD_BITS +: COORD_BITS];
  assign y1 = cmd_data[3*COORD_BITS +: COORD_BITS];

  // order endpoints left to right
  assign swap    = (x0 > x1);
  assign lx      = swap ? x1 : x0;
  assign ly      = swap ? y1 : y0;
  assign rx      = swap ? x0 : x1;
  assign ry      = swap ? y0 : y1;
  assign dx      = rx - lx;
  assign y_down  = (ly > ry);
  assign ady     = y_down ? (ly - ry) : (ry - ly);
  assign shallow = (ady < dx);

  // slope class and walk setup
  always_comb begin
    cmd.glyph     = cmd_data[4*COORD_BITS +: GLYPH_BITS];
    cmd.start_x   = lx;
    cmd.start_y   = ly;
    cmd.stop      = rx;
    cmd.major_y   = 1'b0;
    cmd.major_neg = 1'b0;
    cmd.minor_neg = 1'b0;
    minor_span    = '0;
    major_span    = '0;
    if (x0 == x1) begin
      // vertical, also a single point: walk up from the lower y
      cmd.start_x = x0;
      cmd.start_y = (y0 < y1) ? y0 : y1;
      cmd.stop    = (y0 < y1) ? y1 : y0;
      cmd.major_y = 1'b1;
    end else if (y0 == y1) begin
      // horizontal: walk right from the lower x
      cmd.start_y = y0;
    end else if (shallow) begin
      minor_span    = ady;
      major_span    = dx;
      cmd.minor_neg = y_down;
    end else begin
      // steep, unit slope included
      cmd.stop      = ry;
      cmd.major_y   = 1'b1;
      cmd.major_neg = y_down;
      minor_span    = dx;
      major_span    = ady;
    end
    cmd.a2   = {minor_span, 1'b0};
    cmd.b2   = {major_span, 1'b0};
    cmd.err0 = $signed({{(ERR_W-COORD_BITS-1){1'b0}}, minor_span, 1'b0})
             - $signed({{(ERR_W-COORD_BITS){1'b0}}, major_span});
  end

endmodule

>>> sv/lr_cmd_queue.sv
module lr_cmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lr_pkg::line_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output lr_pkg::line_cmd_t head_cmd,
  output logic              empty
);
  import lr_pkg::*;

  line_cmd_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]       count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full     = (count_r == QUEUE_DEPTH[QPTR_W:0]);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> sv/lr_stepper.sv
module lr_stepper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lr_pkg::line_cmd_t             head_cmd,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);
  import lr_pkg::*;

  step_state_t             state_r, state_nxt;
  coord_t                  cur_x_r, cur_y_r, stop_r;
  logic                    major_y_r, major_neg_r, minor_neg_r;
  logic [COORD_BITS:0]     a2_r, b2_r;
  logic signed [ERR_W-1:0] err_r;
  logic [GLYPH_BITS-1:0]   glyph_r;

  logic                    out_valid_r;
  coord_t                  out_x_r, out_y_r;
  logic [GLYPH_BITS-1:0]   out_glyph_r;
  logic                    out_last_r;

  logic                    out_free, emit, is_last, load, move;
  coord_t                  major_cur, major_step, minor_cur, minor_step;
  logic signed [ERR_W-1:0] err_step;

  // walk decisions
  assign out_free   = !out_valid_r || out_tready;
  assign major_cur  = major_y_r ? cur_y_r : cur_x_r;
  assign minor_cur  = major_y_r ? cur_x_r : cur_y_r;
  assign is_last    = (major_cur == stop_r);
  assign move       = !err_r[ERR_W-1] && (err_r != '0);
  assign major_step = major_neg_r ? major_cur - 1'b1 : major_cur + 1'b1;
  assign minor_step = !move ? minor_cur :
                      (minor_neg_r ? minor_cur - 1'b1 : minor_cur + 1'b1);
  assign err_step   = err_r + $signed({{(ERR_W-COORD_BITS-1){1'b0}}, a2_r})
                    - (move ? $signed({{(ERR_W-COORD_BITS-1){1'b0}}, b2_r}) : '0);

  // control outputs
  always_comb begin
    emit  = 1'b0;
    load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        load = !q_empty;
      end
      ST_WALK: begin
        emit = out_free;
        load = out_free && is_last && !q_empty;
      end
      default: begin
        emit = 1'b0;
        load = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (load) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (emit && is_last && !load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // walk registers: load a new line or take one step
  always_ff @(posedge clk) begin
    if (load) begin
      cur_x_r     <= head_cmd.start_x;
      cur_y_r     <= head_cmd.start_y;
      stop_r      <= head_cmd.stop;
      major_y_r   <= head_cmd.major_y;
      major_neg_r <= head_cmd.major_neg;
      minor_neg_r <= head_cmd.minor_neg;
      a2_r        <= head_cmd.a2;
      b2_r        <= head_cmd.b2;
      err_r       <= head_cmd.err0;
      glyph_r     <= head_cmd.glyph;
    end else if (emit) begin
      cur_x_r <= major_y_r ? minor_step : major_step;
      cur_y_r <= major_y_r ? major_step : minor_step;
      err_r   <= err_step;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r     <= cur_x_r;
      out_y_r     <= cur_y_r;
      out_glyph_r <= glyph_r;
      out_last_r  <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELD_W){1'b0}}, out_glyph_r, out_y_r, out_x_r};

endmodule

>>> sv/line_rasterizer.sv
// Line rasterizer. Each input transaction is one line command (two endpoints
// and a glyph); the block returns one output transaction per pixel of the line,
// with tlast on the final pixel. Vertical lines and single points run from the
// lower y upward, horizontal lines from the lower x, sloped lines from the left
// endpoint with an exact integer midpoint test. The single pixel stepper sends
// one pixel per cycle while out_tready allows, at most 64 pixels per line; the
// next queued line starts in the cycle after the previous line's last
// pixel. A two-entry command queue in front of the stepper takes new commands
// while a line is being walked, so in_tready drops only when the queue is full.
module line_rasterizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // fields from bit 0: start_x, start_y, end_x, end_y, glyph
  input  logic [lr_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // fields from bit 0: pixel_x, pixel_y, pixel_glyph
  output logic [lr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);
  import lr_pkg::*;

  line_cmd_t new_cmd, head_cmd;
  logic      q_full, q_empty, q_pop;

  // classify the incoming command
  lr_classify u_classify (
    .cmd_data (in_tdata),
    .cmd      (new_cmd)
  );

  // queue between classifier and stepper
  lr_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid),
    .push_cmd (new_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  assign in_tready = !q_full;

  // pixel walk and output register
  lr_stepper u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> verif/line_rasterizer_chk.sv
`timescale 1ns / 100ps

// watches both streams, traces each accepted line command into its pixels and
// compares every output transaction with the oldest traced pixel
module line_rasterizer_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // fields from bit 0: start_x, start_y, end_x, end_y, glyph
  input  logic [lr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // fields from bit 0: pixel_x, pixel_y, pixel_glyph
  input  logic [lr_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                          out_tlast,
  output int                            err_count,
  output int                            pending
);
  import lr_pkg::*;

  localparam int MAX_PIXELS = 1 << COORD_BITS;

  typedef struct packed {
    coord_t                px;
    coord_t                py;
    logic [GLYPH_BITS-1:0] glyph;
    logic                  last;
  } pixel_t;

  typedef enum int {
    CLS_VERTICAL,
    CLS_HORIZONTAL,
    CLS_SHALLOW_UP,
    CLS_SHALLOW_DOWN,
    CLS_STEEP_UP,
    CLS_STEEP_DOWN
  } line_class_t;

  pixel_t traced_pixels[$];
  pixel_t want;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  function automatic void push_pixel(int x, int y, logic [GLYPH_BITS-1:0] g, bit last);
    pixel_t p;
    p.px    = coord_t'(x);
    p.py    = coord_t'(y);
    p.glyph = g;
    p.last  = last;
    traced_pixels.push_back(p);
  endfunction

  // midpoint walk of one command, doubled decision value kept exact
  function automatic void trace_line(logic [IN_DATA_W-1:0] cmd);
    int x0, y0, x1, y1, t, dx, dy, c2, x, y, stop, d, n;
    bit last;
    logic [GLYPH_BITS-1:0] g;
    line_class_t cls;
    x0 = int'(cmd[0*COORD_BITS +: COORD_BITS]);
    y0 = int'(cmd[1*COORD_BITS +: COORD_BITS]);
    x1 = int'(cmd[2*COORD_BITS +: COORD_BITS]);
    y1 = int'(cmd[3*COORD_BITS +: COORD_BITS]);
    g  = cmd[4*COORD_BITS +: GLYPH_BITS];
    n  = 0;
    if (x0 == x1) begin
      // vertical or single point, walked from the lower y
      y    = (y0 < y1) ? y0 : y1;
      stop = (y0 < y1) ? y1 : y0;
      do begin
        last = (y >= stop);
        push_pixel(x0, y, g, last);
        n++;
        y++;
      end while (!last && n < MAX_PIXELS);
    end else if (y0 == y1) begin
      x    = (x0 < x1) ? x0 : x1;
      stop = (x0 < x1) ? x1 : x0;
      do begin
        last = (x >= stop);
        push_pixel(x, y0, g, last);
        n++;
        x++;
      end while (!last && n < MAX_PIXELS);
    end else begin
      // sloped: start at the left endpoint
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      c2 = 2 * (x0 * y1 - x1 * y0);
      if (dy > 0 && dy < dx)       cls = CLS_SHALLOW_UP;
      else if (dy < 0 && -dy < dx) cls = CLS_SHALLOW_DOWN;
      else if (dy > 0)             cls = CLS_STEEP_UP;
      else                         cls = CLS_STEEP_DOWN;
      x = x0;
      y = y0;
      do begin
        case (cls)
          CLS_SHALLOW_UP, CLS_SHALLOW_DOWN: last = (x >= x1);
          CLS_STEEP_UP:                     last = (y >= y1);
          default:                          last = (y <= y1);
        endcase
        push_pixel(x, y, g, last);
        n++;
        case (cls)
          CLS_SHALLOW_UP: begin
            d = -dy * (2 * x + 2) + dx * (2 * y + 1) + c2;
            if (d < 0) y++;
            x++;
          end
          CLS_SHALLOW_DOWN: begin
            d = -dy * (2 * x + 2) + dx * (2 * y - 1) + c2;
            if (d > 0) y--;
            x++;
          end
          CLS_STEEP_UP: begin
            d = -dy * (2 * x + 1) + dx * (2 * y + 2) + c2;
            if (d > 0) x++;
            y++;
          end
          default: begin
            d = -dy * (2 * x + 1) + dx * (2 * y - 2) + c2;
            if (d < 0) x++;
            y--;
          end
        endcase
      end while (!last && n < MAX_PIXELS);
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      err_count++;
    end
  endfunction

  // outputs are checked before inputs are traced: a pixel cannot leave in the
  // same cycle its command arrives
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (traced_pixels.size() == 0) begin
          $error("pixel transaction with nothing expected: x=%0d y=%0d",
                 out_tdata[0 +: COORD_BITS], out_tdata[COORD_BITS +: COORD_BITS]);
          err_count++;
        end else begin
          want = traced_pixels.pop_front();
          check_field("pixel_x", want.px, out_tdata[0 +: COORD_BITS]);
          check_field("pixel_y", want.py, out_tdata[COORD_BITS +: COORD_BITS]);
          check_field("pixel_glyph", want.glyph, out_tdata[2*COORD_BITS +: GLYPH_BITS]);
          check_field("last_pixel", want.last, out_tlast);
          check_field("tdata padding", 0, int'(out_tdata >> OUT_FIELD_W));
        end
      end
      if (in_tvalid && in_tready)
        trace_line(in_tdata);
      pending = traced_pixels.size();
    end
  end

endmodule

>>> verif/line_rasterizer_tb.sv
`timescale 1ns / 100ps

module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int RANDOM_LINES = 150;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  int                    err_count;
  int                    pending;

  // steering between the sender and the receiver
  bit no_idle;
  bit hold_req;

  line_rasterizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  line_rasterizer_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .err_count  (err_count),
    .pending    (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_line(int x0, int y0, int x1, int y1, int g);
    return {GLYPH_BITS'(g), coord_t'(y1), coord_t'(x1), coord_t'(y0), coord_t'(x0)};
  endfunction

  // random command, biased toward the special shapes
  function automatic logic [IN_DATA_W-1:0] random_line();
    int x0, y0, x1, y1, len;
    x0 = $urandom_range(0, 63);
    y0 = $urandom_range(0, 63);
    x1 = $urandom_range(0, 63);
    y1 = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      5: x1 = x0;
      6: y1 = y0;
      7: begin
        len = $urandom_range(1, 63 - ((x0 > y0) ? x0 : y0) + 1) - 1;
        x1 = x0 + len;
        y1 = $urandom_range(0, 1) ? y0 + len : y0;
        if (y1 == y0) begin
          // falling diagonal from the top
          y0 = y0 + len;
        end
      end
      8: begin
        x1 = (x0 + $urandom_range(0, 3)) % 64;
        y1 = (y0 + $urandom_range(0, 3)) % 64;
      end
      9: begin
        x1 = x0;
        y1 = y0;
      end
      default: ;
    endcase
    return pack_line(x0, y0, x1, y1, $urandom_range(0, 255));
  endfunction

  // one input transaction, driven at the falling edge
  task automatic send_line(logic [IN_DATA_W-1:0] cmd);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = cmd;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // receiver: random back-pressure, one long hold on request
  initial begin
    int gap;
    bit held;
    gap  = 0;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
      end
      if (no_idle) begin
        out_tready = 1'b1;
      end else if (gap > 0) begin
        out_tready = 1'b0;
        gap--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) gap = pick_gap();
      end
    end
  end

  // stimulus and verdict
  initial begin
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single points at both corners
    send_line(pack_line(0, 0, 0, 0, 8'h00));
    send_line(pack_line(63, 63, 63, 63, 8'hFF));
    // full-height vertical, either endpoint order
    send_line(pack_line(5, 63, 5, 0, 8'h55));
    send_line(pack_line(0, 0, 0, 63, 8'hAA));
    // full-width horizontal
    send_line(pack_line(63, 10, 0, 10, 8'h0F));
    send_line(pack_line(0, 63, 63, 63, 8'hF0));
    // shallow rising and falling
    send_line(pack_line(0, 0, 63, 20, 8'h01));
    send_line(pack_line(0, 63, 63, 40, 8'h80));
    send_line(pack_line(40, 5, 3, 30, 8'h3C));
    // steep rising and falling
    send_line(pack_line(10, 0, 30, 63, 8'hC3));
    send_line(pack_line(2, 63, 20, 0, 8'h7E));
    send_line(pack_line(63, 1, 50, 62, 8'h81));
    // unit slope both ways
    send_line(pack_line(0, 0, 63, 63, 8'h5A));
    send_line(pack_line(63, 0, 0, 63, 8'hA5));
    send_line(pack_line(20, 21, 21, 20, 8'h11));
    // decision ties in every sloped class
    send_line(pack_line(0, 0, 2, 1, 8'h22));
    send_line(pack_line(0, 0, 1, 2, 8'h44));
    send_line(pack_line(0, 1, 2, 0, 8'h88));
    send_line(pack_line(0, 2, 1, 0, 8'hEE));
    send_line(pack_line(61, 59, 63, 62, 8'h77));

    for (int i = 0; i < RANDOM_LINES; i++) begin
      // long receiver hold while commands keep coming
      if (i == 40) begin
        hold_req = 1'b1;
        no_idle  = 1'b1;
      end
      if (i == 48) no_idle = 1'b0;
      // sender waits for the pipe to drain completely
      if (i == 90) begin
        in_tvalid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
      end
      // a stretch with no idling on either side
      if (i == 110) no_idle = 1'b1;
      if (i == 125) no_idle = 1'b0;
      send_line(random_line());
    end
    in_tvalid = 1'b0;
    no_idle   = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
